// ----- sv/sssp_pkg.sv -----
// Shared types, constants and the slot score function for the slot picker.
// No dependencies; every other file refers to it by scoped names.
package sssp_pkg;

   localparam int SLOT_ID_W = 32;
   localparam int NODE_W    = 6;
   localparam int FLAGS_W   = 3;
   localparam int PICK_W    = 7;
   localparam int CNT_W     = 8;
   localparam int SCORE_W   = 15;

   localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

   localparam logic [6:0] SCORE_HEALTHY   = 7'd1;
   localparam logic [6:0] SCORE_INSTALLED = 7'd10;
   localparam logic [6:0] SCORE_RUNNING   = 7'd100;
   localparam logic [SCORE_W-1:0] SCATTER_SCALE = 15'd100;

   // request codes
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_TAG   = 2'd1;
   localparam logic [1:0] REQ_ALLOC = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [SLOT_ID_W-1:0] slot_id;
      logic [NODE_W-1:0]    node_id;
      logic                 unrecoverable;
      logic                 package_installed;
      logic                 all_running;
      logic [PICK_W-1:0]    pick_count;
   } req_item_type;

   typedef struct packed {
      logic [SLOT_ID_W-1:0] chosen_slot;
      logic [NODE_W-1:0]    chosen_node;
      logic                 none_chosen;
      logic                 last;
   } rsp_item_type;

   // flags: bit0 unrecoverable, bit1 package installed, bit2 all running
   typedef struct packed {
      logic [SLOT_ID_W-1:0] id;
      logic [NODE_W-1:0]    node;
      logic [FLAGS_W-1:0]   flags;
   } slot_entry_type;

   typedef struct packed {
      logic wr_en;
      logic clear;
   } cnt_ctl_type;

   typedef struct packed {
      logic clear;
      logic sample;
      logic scatter;
   } best_ctl_type;

   function automatic logic signed [SCORE_W-1:0] slot_score(
      input logic [FLAGS_W-1:0] flags,
      input logic               scatter,
      input logic [CNT_W-1:0]   cnt);
      logic [6:0]         base;
      logic [SCORE_W-1:0] scaled;
      base = (flags[0] ? 7'd0 : SCORE_HEALTHY)
           + (flags[1] ? SCORE_INSTALLED : 7'd0)
           + (flags[2] ? SCORE_RUNNING : 7'd0);
      scaled = SCORE_W'(base) * SCATTER_SCALE;
      if (scatter) begin
         return signed'(scaled - SCORE_W'(cnt));
      end
      return signed'(SCORE_W'(base));
   endfunction

endpackage

// ----- sv/sssp_table.sv -----
// Slot table memory: id, node and flags per buffered slot.
// One write port, one registered read port. Uses sssp_pkg.
module sssp_table #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  sssp_pkg::slot_entry_type      wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output sssp_pkg::slot_entry_type      rd_data
);

   sssp_pkg::slot_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sv/sssp_counts.sv -----
// Per-node held-slot counts: memory plus one valid bit per node so that
// the whole table clears at once. Nodes past the table read as 0. Uses sssp_pkg.
module sssp_counts #(
   parameter int NODES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sssp_pkg::cnt_ctl_type           ctl,
   input  logic [sssp_pkg::NODE_W-1:0]     wr_node,
   input  logic [sssp_pkg::CNT_W-1:0]      wr_data,
   input  logic [sssp_pkg::NODE_W-1:0]     rd_node,
   output logic [sssp_pkg::CNT_W-1:0]      rd_data
);

   localparam int NAW = $clog2(NODES);

   logic [sssp_pkg::CNT_W-1:0] mem [NODES];
   logic [NODES-1:0]           valid_ff;
   logic [sssp_pkg::CNT_W-1:0] mem_q_ff;
   logic                       hit_ff;

   logic [NAW+5:0]  wr_ext, rd_ext;
   logic [NAW-1:0]  wr_idx, rd_idx;
   logic            wr_ok, rd_ok;

   assign wr_ext = (NAW+6)'(wr_node);
   assign rd_ext = (NAW+6)'(rd_node);
   assign wr_idx = wr_ext[NAW-1:0];
   assign rd_idx = rd_ext[NAW-1:0];
   assign wr_ok  = 32'(wr_node) < NODES;
   assign rd_ok  = 32'(rd_node) < NODES;

   always_ff @(posedge clock) begin
      if (ctl.wr_en && wr_ok) begin
         mem[wr_idx] <= wr_data;
      end
      mem_q_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         hit_ff <= rd_ok && valid_ff[rd_idx];
         // clear wins over a same-cycle write
         if (ctl.clear) begin
            valid_ff <= '0;
         end else if (ctl.wr_en && wr_ok) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   assign rd_data = hit_ff ? mem_q_ff : '0;

endmodule

// ----- sv/sssp_best.sv -----
// Shared score unit: scores one slot per cycle and keeps the running best.
// Strict greater-than keeps the earliest slot on a tie. Uses sssp_pkg.
module sssp_best #(
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sssp_pkg::best_ctl_type           ctl,
   input  logic [$clog2(DEPTH)-1:0]         in_idx,
   input  sssp_pkg::slot_entry_type         in_entry,
   input  logic [sssp_pkg::CNT_W-1:0]       in_cnt,
   output logic                             found,
   output logic [$clog2(DEPTH)-1:0]         best_idx,
   output logic [sssp_pkg::SLOT_ID_W-1:0]   best_id,
   output logic [sssp_pkg::NODE_W-1:0]      best_node,
   output logic [sssp_pkg::CNT_W-1:0]       best_cnt
);

   logic                                    found_ff;
   logic signed [sssp_pkg::SCORE_W-1:0]     score_ff;
   logic signed [sssp_pkg::SCORE_W-1:0]     score;
   logic [$clog2(DEPTH)-1:0]                idx_ff;
   logic [sssp_pkg::SLOT_ID_W-1:0]          id_ff;
   logic [sssp_pkg::NODE_W-1:0]             node_ff;
   logic [sssp_pkg::CNT_W-1:0]              cnt_ff;
   logic                                    take;

   assign score = sssp_pkg::slot_score(in_entry.flags, ctl.scatter, in_cnt);
   assign take  = ctl.sample && (!found_ff || (score > score_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !ctl.clear) begin
         score_ff <= score;
         idx_ff   <= in_idx;
         id_ff    <= in_entry.id;
         node_ff  <= in_entry.node;
         cnt_ff   <= in_cnt;
      end
   end

   assign found     = found_ff;
   assign best_idx  = idx_ff;
   assign best_id   = id_ff;
   assign best_node = node_ff;
   assign best_cnt  = cnt_ff;

endmodule

// ----- sv/scored_scatter_slot_picker.sv -----
// Scored slot picker: buffered slot table, per-node held counts and a
// sequencer that drives one shared score/compare unit. Uses sssp_pkg,
// sssp_table, sssp_counts and sssp_best.
//
// Use: an item is taken on start while busy is low. Load, tag and clear
// items give no result; an allocate item gives one or more results, each
// shown for a single cycle with rsp_valid high, the final one with last set.
// An empty allocation gives one result with none_chosen and last set.
// csr_data (scatter_mode) is written on csr_valid with csr_ready, which is
// high whenever the block is not busy.
//
// Clear and an empty allocation finish while idle; a tag reads the node
// count, then writes it back incremented. A load walks the table for a
// duplicate id. Each pick of an allocation walks the table once through a
// two-stage read pipe (table, then node count) into the score unit; its
// result is registered and appears in the cycle after the walk drains.
// Reset empties the table, zeroes the node counts and taken marks and sets
// plain mode. Results are never held back; the receiver must take each one.
module scored_scatter_slot_picker #(
   parameter int MAX_SLOTS = 64,
   parameter int MAX_NODES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  sssp_pkg::req_item_type  req_data,
   output logic                    rsp_valid,
   output sssp_pkg::rsp_item_type  rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_data
);

   localparam int AW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_LOAD_SCAN = 3'd1;
   localparam logic [2:0] ST_TAG_RD    = 3'd2;
   localparam logic [2:0] ST_TAG_WR    = 3'd3;
   localparam logic [2:0] ST_PICK_SCAN = 3'd4;

   logic [2:0]                   state_ff, state_in;
   sssp_pkg::req_item_type       req_ff, req_in;
   logic                         mode_ff, mode_in;
   logic [CW-1:0]                slot_count_ff, slot_count_in;
   logic [CW-1:0]                issue_ff, issue_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic [AW-1:0]                s1_idx_ff;
   logic                         s2_valid_ff, s2_valid_in;
   logic [AW-1:0]                s2_idx_ff;
   sssp_pkg::slot_entry_type     s2_entry_ff;
   logic                         s2_taken_ff;
   logic                         match_ff, match_in;
   logic [AW-1:0]                match_idx_ff, match_idx_in;
   logic [sssp_pkg::PICK_W-1:0]  want_ff, want_in;
   logic [sssp_pkg::PICK_W-1:0]  picked_ff, picked_in;
   logic [MAX_SLOTS-1:0]         taken_ff, taken_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   sssp_pkg::rsp_item_type       rsp_data_ff, rsp_data_in;

   logic                         accept, scanning, issuing, drained, pick_last;
   logic [sssp_pkg::PICK_W-1:0]  want_req, picked_next;
   logic [CW-1:0]                issue_next;

   // table ports
   logic                         tbl_wr_en;
   logic [AW-1:0]                tbl_wr_addr;
   sssp_pkg::slot_entry_type     tbl_wr_data, tbl_rd_data, req_entry;

   // count ports
   sssp_pkg::cnt_ctl_type        cnt_ctl;
   logic [sssp_pkg::NODE_W-1:0]  cnt_wr_node, cnt_rd_node;
   logic [sssp_pkg::CNT_W-1:0]   cnt_wr_data, cnt_rd_data, cnt_bumped;

   // score unit ports
   sssp_pkg::best_ctl_type       best_ctl;
   logic                         best_found;
   logic [AW-1:0]                best_idx;
   logic [sssp_pkg::SLOT_ID_W-1:0] best_id;
   logic [sssp_pkg::NODE_W-1:0]  best_node;
   logic [sssp_pkg::CNT_W-1:0]   best_cnt;

   assign busy      = state_ff != ST_IDLE;
   assign accept    = start && !busy;
   assign csr_ready = !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign scanning   = (state_ff == ST_LOAD_SCAN) || (state_ff == ST_PICK_SCAN);
   assign issuing    = scanning && (issue_ff != slot_count_ff);
   assign issue_next = issue_ff + CW'(1);
   assign drained    = (issue_ff == slot_count_ff) && !s1_valid_ff && !s2_valid_ff;
   assign want_req   = (mode_ff && (req_data.pick_count == '0)) ?
                       sssp_pkg::PICK_W'(1) : req_data.pick_count;
   assign picked_next = picked_ff + sssp_pkg::PICK_W'(1);
   // picks never exceed the table size, so the last one is known in advance
   assign pick_last  = (picked_next >= want_ff) ||
                       (32'(picked_next) >= 32'(slot_count_ff));
   assign cnt_bumped = (best_cnt == sssp_pkg::COUNT_MAX) ? best_cnt :
                       best_cnt + sssp_pkg::CNT_W'(1);

   assign req_entry.id    = req_ff.slot_id;
   assign req_entry.node  = req_ff.node_id;
   assign req_entry.flags = {req_ff.all_running, req_ff.package_installed,
                             req_ff.unrecoverable};

   assign cnt_rd_node = (state_ff == ST_TAG_RD) ? req_ff.node_id : tbl_rd_data.node;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      mode_in       = mode_ff;
      slot_count_in = slot_count_ff;
      issue_in      = issuing ? issue_next : issue_ff;
      s1_valid_in   = issuing;
      s2_valid_in   = s1_valid_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      want_in       = want_ff;
      picked_in     = picked_ff;
      taken_in      = taken_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = slot_count_ff[AW-1:0];
      tbl_wr_data   = req_entry;
      cnt_ctl       = '0;
      cnt_wr_node   = req_ff.node_id;
      cnt_wr_data   = cnt_bumped;
      best_ctl.clear   = 1'b0;
      best_ctl.sample  = (state_ff == ST_PICK_SCAN) && s2_valid_ff && !s2_taken_ff;
      best_ctl.scatter = mode_ff;

      if (csr_valid && csr_ready) begin
         mode_in = csr_data;
      end

      // duplicate id search during a load walk
      if ((state_ff == ST_LOAD_SCAN) && s1_valid_ff && (tbl_rd_data.id == req_ff.slot_id)) begin
         match_in     = 1'b1;
         match_idx_in = s1_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               unique case (req_data.req_type)
                  sssp_pkg::REQ_LOAD: begin
                     match_in = 1'b0;
                     issue_in = '0;
                     state_in = ST_LOAD_SCAN;
                  end
                  sssp_pkg::REQ_TAG: begin
                     state_in = ST_TAG_RD;
                  end
                  sssp_pkg::REQ_CLEAR: begin
                     slot_count_in = '0;
                  end
                  sssp_pkg::REQ_ALLOC: begin
                     if ((want_req == '0) || (slot_count_ff == '0)) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{chosen_slot: '0, chosen_node: '0,
                                         none_chosen: 1'b1, last: 1'b1};
                        cnt_ctl.clear = 1'b1;
                     end else begin
                        want_in        = want_req;
                        picked_in      = '0;
                        issue_in       = '0;
                        best_ctl.clear = 1'b1;
                        state_in       = ST_PICK_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD_SCAN: begin
            if (drained) begin
               state_in = ST_IDLE;
               if (match_ff) begin
                  tbl_wr_en   = 1'b1;
                  tbl_wr_addr = match_idx_ff;
               end else if (32'(slot_count_ff) < MAX_SLOTS) begin
                  tbl_wr_en     = 1'b1;
                  slot_count_in = slot_count_ff + CW'(1);
               end
            end
         end
         ST_TAG_RD: begin
            state_in = ST_TAG_WR;
         end
         ST_TAG_WR: begin
            cnt_ctl.wr_en = 1'b1;
            cnt_wr_data   = (cnt_rd_data == sssp_pkg::COUNT_MAX) ? cnt_rd_data :
                            cnt_rd_data + sssp_pkg::CNT_W'(1);
            state_in      = ST_IDLE;
         end
         ST_PICK_SCAN: begin
            if (drained) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{chosen_slot: best_id, chosen_node: best_node,
                                none_chosen: 1'b0, last: pick_last};
               if (pick_last) begin
                  taken_in      = '0;
                  cnt_ctl.clear = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  taken_in[best_idx] = 1'b1;
                  cnt_ctl.wr_en      = mode_ff;
                  cnt_wr_node        = best_node;
                  picked_in          = picked_next;
                  issue_in           = '0;
                  best_ctl.clear     = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= 1'b0;
         slot_count_ff <= '0;
         issue_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         match_ff      <= 1'b0;
         taken_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         slot_count_ff <= slot_count_in;
         issue_ff      <= issue_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         match_ff      <= match_in;
         taken_ff      <= taken_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      match_idx_ff <= match_idx_in;
      want_ff      <= want_in;
      picked_ff    <= picked_in;
      rsp_data_ff  <= rsp_data_in;
      s1_idx_ff    <= issue_ff[AW-1:0];
      s2_idx_ff    <= s1_idx_ff;
      s2_entry_ff  <= tbl_rd_data;
      s2_taken_ff  <= taken_ff[s1_idx_ff];
   end

   sssp_table #(
      .DEPTH (MAX_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (tbl_rd_data)
   );

   sssp_counts #(
      .NODES (MAX_NODES)
   ) u_counts (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cnt_ctl),
      .wr_node (cnt_wr_node),
      .wr_data (cnt_wr_data),
      .rd_node (cnt_rd_node),
      .rd_data (cnt_rd_data)
   );

   sssp_best #(
      .DEPTH (MAX_SLOTS)
   ) u_best (
      .clock     (clock),
      .reset     (reset),
      .ctl       (best_ctl),
      .in_idx    (s2_idx_ff),
      .in_entry  (s2_entry_ff),
      .in_cnt    (cnt_rd_data),
      .found     (best_found),
      .best_idx  (best_idx),
      .best_id   (best_id),
      .best_node (best_node),
      .best_cnt  (best_cnt)
   );

   // taken marks exist only inside an allocation
   a_taken_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (taken_ff == '0))
      else $error("taken marks left set outside an allocation");

   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("scan pipe busy while idle");

   a_pick_found: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PICK_SCAN) && drained) |-> best_found)
      else $error("pick finished without a candidate");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.none_chosen) |-> rsp_data_ff.last)
      else $error("empty result not marked last");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(slot_count_ff) <= MAX_SLOTS)
      else $error("slot count beyond table size");

endmodule
